FILE: rtl/rba_pkg.sv
// Shared types and constants for the ring buffer allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rba_pkg;

  // Fixed widths of the request, response and register fields.
  localparam int FIELD_W             = 17;
  localparam int ALIGN_W             = 4;
  localparam int ALIGN_MASK_W        = (1 << ALIGN_W) - 1;
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 17;
  localparam int OFFSET_BITS_DEFAULT = 17;

  // Register reset values.
  localparam logic [FIELD_W-1:0] BUFFER_SIZE_RESET = FIELD_W'(65536);
  localparam logic [ALIGN_W-1:0] ALIGN_SHIFT_RESET = '0;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_BUFFER_SIZE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ALIGN_SHIFT = CFG_INDEX_W'(1);

  typedef enum logic [1:0] {
    ACT_ALLOC      = 2'd0,
    ACT_COMMIT     = 2'd1,
    ACT_BEGIN_READ = 2'd2,
    ACT_END_READ   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_WAIT      = 3'd1,
    STATUS_PENDING   = 3'd2,
    STATUS_TOO_LARGE = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_t;

  typedef struct packed {
    action_t              action;
    logic [FIELD_W-1:0]   request_size;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [FIELD_W-1:0]   offset;
    logic [FIELD_W-1:0]   length;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/ring_buffer_allocator_top.sv
// Top level of the ring buffer allocator.
// Instantiates rba_in_stage, rba_engine and rba_out_stage; uses rba_pkg.
`default_nettype none

// The ring buffer allocator keeps the write and read offsets of a circular
// command buffer and at most one pending allocation. Each request carries an
// action (allocate, commit, begin read, end read) and a size; each request
// produces exactly one response with a status, an offset and a length, in
// request order. An allocation that would run over unread data answers with
// the wait status and changes nothing, so the requester must retry it later.
// A request is registered on acceptance and evaluated against the registered
// offsets while held in the input register; its response is loaded into the
// result register once that register is empty or its response is being
// taken. One request per cycle is sustained as long as responses are taken.
// The only thing that holds a request back is a response that has not yet
// been taken. The buffer size and the alignment shift are written through
// the configuration port; the user must write them only while no request is
// in flight, as the block itself does not enforce this.

module ring_buffer_allocator_top #(
  parameter int OFFSET_BITS = rba_pkg::OFFSET_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire rba_pkg::req_t                   req,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output rba_pkg::rsp_t                        rsp,
  input  wire logic                            cfg_we,
  input  wire logic [rba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rba_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rba_pkg::*;

  logic stage_valid;
  req_t stage_req;
  rsp_t rsp_next;
  logic can_load;
  logic fire;

  // The held request is evaluated, and the offsets move, in the same cycle
  // that its response is loaded into the result register.
  assign fire = stage_valid && can_load;

  rba_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .advance     (fire),
    .stage_valid (stage_valid),
    .stage_req   (stage_req)
  );

  rba_engine #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .stage_req (stage_req),
    .rsp_next  (rsp_next)
  );

  rba_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (stage_valid),
    .rsp_next  (rsp_next),
    .can_load  (can_load),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/rba_in_stage.sv
// Input register of the ring buffer allocator: holds one accepted request.
// Depends on rba_pkg for the request type.
`default_nettype none

module rba_in_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire rba_pkg::req_t req,
  input  wire logic          advance,
  output logic               stage_valid,
  output rba_pkg::req_t      stage_req
);
  import rba_pkg::*;

  // The held request leaves when the engine takes it, so a new one can
  // enter in the same cycle.
  assign req_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stage_req <= req;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rba_engine.sv
// Offset state, configuration registers and the per-request decision logic.
// Depends on rba_pkg for types, codes and field widths.
`default_nettype none

module rba_engine #(
  parameter int OFFSET_BITS = rba_pkg::OFFSET_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [rba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rba_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            fire,
  input  wire rba_pkg::req_t                   stage_req,
  output rba_pkg::rsp_t                        rsp_next
);
  import rba_pkg::*;

  // Working width: holds any offset, any aligned size and their sum.
  localparam int CW = ((OFFSET_BITS > FIELD_W + 1) ? OFFSET_BITS : FIELD_W + 1) + 1;

  logic [FIELD_W-1:0]     buffer_size;
  logic [ALIGN_W-1:0]     align_shift;
  logic [OFFSET_BITS-1:0] write_offset, write_offset_next;
  logic [OFFSET_BITS-1:0] read_offset, read_offset_next;
  logic                   alloc_pending, alloc_pending_next;
  logic [OFFSET_BITS-1:0] pending_start, pending_start_next;
  logic [OFFSET_BITS-1:0] pending_length, pending_length_next;

  logic [ALIGN_MASK_W-1:0] align_mask;
  logic [CW-1:0] asz_c, size_c, wo_c, ro_c, ps_c, pl_c;
  logic [CW-1:0] start_c, end_raw_c, end_c, commit_end_c;
  logic [CW-1:0] ro_eff_c, rend_c, consumed_c, consumed_sat_c;

  always_comb begin
    align_mask = ~({ALIGN_MASK_W{1'b1}} << align_shift);
    asz_c      = (CW'(stage_req.request_size) + CW'(align_mask)) & ~CW'(align_mask);
    size_c     = CW'(buffer_size);
    wo_c       = CW'(write_offset);
    ro_c       = CW'(read_offset);
    ps_c       = CW'(pending_start);
    pl_c       = CW'(pending_length);

    // Allocation starts again at zero when the writer sits at the end.
    start_c   = (wo_c < size_c) ? wo_c : '0;
    end_raw_c = start_c + asz_c;
    end_c     = (end_raw_c > size_c) ? size_c : end_raw_c;

    commit_end_c = ps_c + pl_c;

    // Readable span: up to the writer, or up to the end when the writer has
    // wrapped; a reader stranded at the end while behind the writer wraps.
    if (wo_c >= ro_c) begin
      ro_eff_c = ro_c;
      rend_c   = wo_c;
    end else if (ro_c >= size_c) begin
      ro_eff_c = '0;
      rend_c   = wo_c;
    end else begin
      ro_eff_c = ro_c;
      rend_c   = size_c;
    end

    consumed_c     = ro_c + asz_c;
    consumed_sat_c = (consumed_c > size_c) ? size_c : consumed_c;
  end

  always_comb begin
    write_offset_next   = write_offset;
    read_offset_next    = read_offset;
    alloc_pending_next  = alloc_pending;
    pending_start_next  = pending_start;
    pending_length_next = pending_length;
    rsp_next            = '{status: STATUS_OK, offset: '0, length: '0};
    case (stage_req.action)
      ACT_ALLOC: begin
        if (alloc_pending) begin
          rsp_next.status = STATUS_PENDING;
        end else if (asz_c >= size_c) begin
          rsp_next.status = STATUS_TOO_LARGE;
        end else if (ro_c != wo_c && start_c <= ro_c && ro_c <= end_c) begin
          rsp_next.status = STATUS_WAIT;
        end else begin
          alloc_pending_next  = 1'b1;
          pending_start_next  = start_c[OFFSET_BITS-1:0];
          pending_length_next = OFFSET_BITS'(end_c - start_c);
          rsp_next.offset     = FIELD_W'(CW'(pending_start_next));
          rsp_next.length     = FIELD_W'(CW'(pending_length_next));
        end
      end
      ACT_COMMIT: begin
        if (alloc_pending) begin
          write_offset_next  = commit_end_c[OFFSET_BITS-1:0];
          alloc_pending_next = 1'b0;
          rsp_next.offset    = ps_c[FIELD_W-1:0];
          rsp_next.length    = pl_c[FIELD_W-1:0];
        end
      end
      ACT_BEGIN_READ: begin
        if (ro_c == wo_c) begin
          rsp_next.status = STATUS_EMPTY;
        end else begin
          read_offset_next = ro_eff_c[OFFSET_BITS-1:0];
          if (ro_eff_c < rend_c) begin
            rsp_next.offset = ro_eff_c[FIELD_W-1:0];
            rsp_next.length = FIELD_W'(rend_c - ro_eff_c);
          end else begin
            rsp_next.status = STATUS_EMPTY;
          end
        end
      end
      ACT_END_READ: begin
        read_offset_next = consumed_sat_c[OFFSET_BITS-1:0];
        rsp_next.offset  = FIELD_W'(CW'(read_offset_next));
      end
      default: begin
        rsp_next.status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_offset   <= '0;
      read_offset    <= '0;
      alloc_pending  <= 1'b0;
      pending_start  <= '0;
      pending_length <= '0;
    end else if (fire) begin
      write_offset   <= write_offset_next;
      read_offset    <= read_offset_next;
      alloc_pending  <= alloc_pending_next;
      pending_start  <= pending_start_next;
      pending_length <= pending_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= BUFFER_SIZE_RESET;
      align_shift <= ALIGN_SHIFT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUFFER_SIZE: buffer_size <= cfg_data[FIELD_W-1:0];
        REG_ALIGN_SHIFT: align_shift <= cfg_data[ALIGN_W-1:0];
        default: begin
          buffer_size <= buffer_size;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rba_out_stage.sv
// Result register of the ring buffer allocator with its valid flag.
// Depends on rba_pkg for the response type.
`default_nettype none

module rba_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire rba_pkg::rsp_t rsp_next,
  output logic               can_load,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output rba_pkg::rsp_t      rsp
);
  import rba_pkg::*;

  assign can_load = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (can_load) begin
      rsp_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/rba_checker.sv
// Port-level checks for the ring buffer allocator, bound to its top level.
// Depends on rba_pkg and on ring_buffer_allocator_top.
`default_nettype none

module rba_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire logic          req_ready,
  input  wire rba_pkg::req_t req,
  input  wire logic          rsp_valid,
  input  wire logic          rsp_ready,
  input  wire rba_pkg::rsp_t rsp
);
  import rba_pkg::*;

  // A waiting request keeps its payload until it is taken.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while waiting");

  // A stalled response keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // A failed request reports no offset and no length.
  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STATUS_OK |-> rsp.offset == '0 && rsp.length == '0)
    else $error("non-ok response carries offset or length");

  // After an accepted request, a response (its own or an older stalled one) is on show.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) ##1 !rst |=> rsp_valid)
    else $error("response missing two cycles after a request");

  // With no response outstanding, the block always takes a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request refused with the result register empty");

endmodule

bind ring_buffer_allocator_top rba_checker u_rba_checker (.*);

`default_nettype wire

FILE: dv/rba_response_checker.sv
// Response checker for the ring buffer allocator testbench.
// Watches the request, response and configuration ports and keeps its own copy
// of the offsets. Depends on rba_pkg only.

module rba_response_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  input  wire logic                            req_ready,
  input  wire rba_pkg::req_t                   req,
  input  wire logic                            rsp_valid,
  input  wire logic                            rsp_ready,
  input  wire rba_pkg::rsp_t                   rsp,
  input  wire logic                            cfg_we,
  input  wire logic [rba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rba_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                   owed_count,
  output int                                   error_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import rba_pkg::*;

  // Mirror of the configuration and of the pointer state.
  logic [FIELD_W-1:0] buf_bytes;
  logic [ALIGN_W-1:0] align_log;
  logic [FIELD_W-1:0] wr_ptr;
  logic [FIELD_W-1:0] rd_ptr;
  logic               held_valid;
  logic [FIELD_W-1:0] held_start;
  logic [FIELD_W-1:0] held_len;

  rsp_t owed_responses[$];
  rsp_t want;
  int   errors = 0;

  function automatic logic [63:0] round_up(input logic [63:0] n);
    logic [63:0] m;
    m = (64'd1 << align_log) - 64'd1;
    return (n + m) & ~m;
  endfunction

  // Works out the response to one request and moves the mirrored state on.
  function automatic rsp_t next_response(input req_t r);
    logic [63:0] size;
    logic [63:0] asz;
    logic [63:0] start;
    logic [63:0] stop;
    logic [63:0] rend;
    logic [63:0] sum;
    rsp_t        o;
    size     = buf_bytes;
    o        = '0;
    o.status = STATUS_OK;
    case (r.action)
      ACT_ALLOC: begin
        asz = round_up(r.request_size);
        if (held_valid) begin
          o.status = STATUS_PENDING;
        end else if (asz >= size) begin
          o.status = STATUS_TOO_LARGE;
        end else begin
          start = (wr_ptr < size) ? wr_ptr : 64'd0;
          stop  = start + asz;
          if (stop > size) stop = size;
          if (rd_ptr != wr_ptr && start <= rd_ptr && rd_ptr <= stop) begin
            o.status = STATUS_WAIT;
          end else begin
            held_valid = 1'b1;
            held_start = start[FIELD_W-1:0];
            held_len   = FIELD_W'(stop - start);
            o.offset   = held_start;
            o.length   = held_len;
          end
        end
      end
      ACT_COMMIT: begin
        if (held_valid) begin
          o.offset   = held_start;
          o.length   = held_len;
          wr_ptr     = held_start + held_len;
          held_valid = 1'b0;
        end
      end
      ACT_BEGIN_READ: begin
        if (rd_ptr == wr_ptr) begin
          o.status = STATUS_EMPTY;
        end else begin
          if (wr_ptr >= rd_ptr) begin
            rend = wr_ptr;
          end else if (rd_ptr >= size) begin
            // The reader wraps even when nothing turns out to be readable.
            rd_ptr = '0;
            rend   = wr_ptr;
          end else begin
            rend = size;
          end
          if (rd_ptr < rend) begin
            o.offset = rd_ptr;
            o.length = FIELD_W'(rend - rd_ptr);
          end else begin
            o.status = STATUS_EMPTY;
          end
        end
      end
      ACT_END_READ: begin
        sum = rd_ptr + round_up(r.request_size);
        if (sum > size) sum = size;
        rd_ptr   = sum[FIELD_W-1:0];
        o.offset = rd_ptr;
      end
      default: begin
        o.status = STATUS_OK;
      end
    endcase
    return o;
  endfunction

  task automatic compare_field(input string label, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, label, exp_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      buf_bytes  = BUFFER_SIZE_RESET;
      align_log  = ALIGN_SHIFT_RESET;
      wr_ptr     = '0;
      rd_ptr     = '0;
      held_valid = 1'b0;
      held_start = '0;
      held_len   = '0;
      owed_responses.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BUFFER_SIZE) buf_bytes = cfg_data;
        else if (cfg_index == REG_ALIGN_SHIFT) align_log = cfg_data[ALIGN_W-1:0];
      end
      // Responses are compared before this edge's request is queued.
      if (rsp_valid && rsp_ready) begin
        if (owed_responses.size() == 0) begin
          errors++;
          $display("%0t: unexpected response: expected none, %s %0d offset %0d length %0d",
                   $time, "got status", rsp.status, rsp.offset, rsp.length);
        end else begin
          want = owed_responses.pop_front();
          compare_field("status", want.status, rsp.status);
          compare_field("offset", want.offset, rsp.offset);
          compare_field("length", want.length, rsp.length);
        end
      end
      if (req_valid && req_ready) owed_responses.push_back(next_response(req));
    end
    owed_count  <= owed_responses.size();
    error_count <= errors;
  end

endmodule

FILE: dv/ring_buffer_allocator_top_test.sv
// Testbench top for the ring buffer allocator: clock, reset, stimulus and verdict.
// Instantiates ring_buffer_allocator_top and rba_response_checker; uses rba_pkg.

module ring_buffer_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rba_pkg::*;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_ready;
  req_t                   req       = '0;
  logic                   rsp_valid;
  logic                   rsp_ready = 1'b0;
  rsp_t                   rsp;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int owed_count;
  int error_count;

  // Stimulus bookkeeping. cur_size only shapes the random sizes; the checker
  // keeps its own copy of the configuration for prediction.
  int sent       = 0;
  int rsp_taken  = 0;
  int cur_size   = 65536;
  bit tx_steady  = 1'b0;
  bit rx_steady  = 1'b0;
  int rx_stall   = 0;

  // Fixed settings for the random phases, the extremes among them. Between
  // them every bit of both registers is written both ways.
  logic [FIELD_W-1:0] phase_size [7] = '{17'd1, 17'd65536, 17'd100, 17'd4096,
                                         17'd37, 17'd65535, 17'd512};
  logic [ALIGN_W-1:0] phase_shift [7] = '{4'd0, 4'd12, 4'd3, 4'd12, 4'd1, 4'd5, 4'd4};

  always #5 clk = ~clk;

  ring_buffer_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rba_response_checker rsp_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .owed_count  (owed_count),
    .error_count (error_count)
  );

  // Idle lengths for both sides: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Request sizes are mostly small against the buffer, so that allocations
  // and reads walk round the ring; some land near the buffer size, where
  // clipping and the too-large check live, and a few cover the whole field.
  function automatic logic [FIELD_W-1:0] pick_size(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 65) return FIELD_W'($urandom_range(1, (span > 4) ? span / 4 : 1));
    if (r < 85) return FIELD_W'($urandom_range(0, span));
    if (r < 93) return FIELD_W'($urandom_range((span > 2) ? span - 2 : 0, span + 2));
    return FIELD_W'($urandom_range(0, 17'h1FFFF));
  endfunction

  // Offers one request and returns at the edge where it is accepted. Valid
  // is left high, so a following request goes out back to back; it is only
  // lowered when a gap is wanted or by drain, never in the step where it is raised.
  task automatic issue(input action_t act, input logic [FIELD_W-1:0] amount);
    int   gap;
    req_t item;
    gap               = tx_steady ? 0 : pick_gap();
    item.action       = act;
    item.request_size = amount;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    sent++;
  endtask

  // Stops offering and waits until every response owed has been taken. The
  // first edge lets the checker's count take in the last accepted request.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges; the write enable is lowered
  // once, after the second write.
  task automatic set_config(input logic [FIELD_W-1:0] size, input logic [ALIGN_W-1:0] shift);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BUFFER_SIZE;
    cfg_data  <= size;
    @(posedge clk);
    cfg_index <= REG_ALIGN_SHIFT;
    cfg_data  <= CFG_DATA_W'(shift);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_size  = (size == '0) ? 1 : int'(size);
  endtask

  // Mostly well-formed traffic: allocate then commit, with the odd second
  // allocate to hit the pending case and the odd missing commit; begin read
  // followed by end read; and a share of single requests of any kind.
  task automatic random_traffic(input int quota);
    int stop_at;
    int pick;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      if ($urandom_range(0, 31) == 0) tx_steady = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        issue(ACT_ALLOC, pick_size(cur_size));
        if ($urandom_range(0, 9) == 0) issue(ACT_ALLOC, pick_size(cur_size));
        if ($urandom_range(0, 9) != 0) issue(ACT_COMMIT, pick_size(cur_size));
      end else if (pick < 85) begin
        issue(ACT_BEGIN_READ, pick_size(cur_size));
        issue(ACT_END_READ, pick_size(cur_size));
      end else begin
        issue(action_t'($urandom_range(0, 3)), pick_size(cur_size));
      end
    end
  endtask

  // Response side. Ready idles at random, with long quiet spells of none. At
  // two points in the run it is held low for a long stretch while requests
  // keep coming, so that the block fills up and holds back its input.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rx_stall  = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_taken++;
        if (rsp_taken == 150 || rsp_taken == 1000) rx_stall = 300;
      end
      if (rx_stall > 0) begin
        rsp_ready <= 1'b0;
        rx_stall--;
      end else begin
        rsp_ready <= 1'b1;
        if ($urandom_range(0, 255) == 0) rx_steady = ~rx_steady;
        if (!rx_steady) rx_stall = pick_gap();
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_config(17'd65536, 4'd0);

    // Directed part, at the largest buffer and byte alignment. The comments
    // give the state the checker should see after each request.
    issue(ACT_BEGIN_READ, 17'd0);        // empty ring: nothing to read
    issue(ACT_COMMIT, 17'd0);            // commit with nothing pending is ignored
    issue(ACT_ALLOC, 17'd0);             // zero-length grant at 0
    issue(ACT_ALLOC, 17'd5);             // a second allocation while one is pending
    issue(ACT_COMMIT, 17'd0);
    issue(ACT_ALLOC, 17'd65536);         // exactly the buffer size is too large
    issue(ACT_ALLOC, 17'h1FFFF);         // the largest field value
    issue(ACT_ALLOC, 17'd65535);         // the largest grant
    issue(ACT_COMMIT, 17'd0);            // writer now at 65535
    issue(ACT_BEGIN_READ, 17'd0);        // span 0 to 65535
    issue(ACT_END_READ, 17'd100);
    issue(ACT_ALLOC, 17'd200);           // clipped at the buffer end to one byte
    issue(ACT_COMMIT, 17'd0);            // writer sits at the end
    issue(ACT_ALLOC, 17'd50);            // writer at the end: start again at 0
    issue(ACT_COMMIT, 17'd0);            // writer at 50, behind the reader
    issue(ACT_ALLOC, 17'd60);            // reader in the way: wait
    issue(ACT_BEGIN_READ, 17'd0);        // span from the reader to the end
    issue(ACT_END_READ, 17'h1FFFF);      // saturates at the buffer size
    issue(ACT_BEGIN_READ, 17'd0);        // reader wraps to 0, span 0 to 50
    issue(ACT_END_READ, 17'd50);         // reader meets writer
    issue(ACT_ALLOC, 17'd65486);         // equal offsets: the reader is not in the way
    issue(ACT_COMMIT, 17'd0);            // writer at the end again
    issue(ACT_ALLOC, 17'd0);             // zero-length grant at 0
    issue(ACT_COMMIT, 17'd0);            // writer at 0
    issue(ACT_END_READ, 17'h1FFFF);      // reader to the end
    issue(ACT_BEGIN_READ, 17'd0);        // wraps, yet nothing is readable
    drain();

    // Random phases, one per setting; the last setting is drawn at random.
    for (int p = 0; p < 8; p++) begin
      if (p < 7) set_config(phase_size[p], phase_shift[p]);
      else set_config(FIELD_W'($urandom_range(1, 65536)), ALIGN_W'($urandom_range(0, 12)));
      random_traffic(240);
      drain();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
